>>> design/ise_pkg.sv
// ============================================================================
// ise_pkg
// Shared sizes and types for the insertion sort engine.
// ============================================================================
package ise_pkg;

    // Store depth and derived widths
    localparam int DEPTH  = 32;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int DATA_W = 32;

    // Store write request
    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] data;
    } ise_wr_t;

endpackage

>>> design/ise_store.sv
// ============================================================================
// ise_store
// Sorted element store: one write port, one read port, registered read data.
// ============================================================================
module ise_store (
    input  logic                           clk,
    input  ise_pkg::ise_wr_t               wr,
    input  logic [ise_pkg::ADDR_W-1:0]     rd_addr,
    output logic [ise_pkg::DATA_W-1:0]     rd_data
);

    logic [ise_pkg::DATA_W-1:0] mem [ise_pkg::DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
    end

    // Read port, registered read data
    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule

>>> design/insertion_sort_engine_top.sv
// ============================================================================
// insertion_sort_engine_top
// Stable ascending insertion sort of signed 32-bit sets held in one store.
// ============================================================================
//
//  Channel  Direction  Signals                       Payload
//  -------  ---------  ----------------------------  -------------------------
//  s_*      in         s_tvalid s_tready s_tdata     tdata = value
//                      s_tlast                       tlast = final_item
//  m_*      out        m_tvalid m_tready m_tdata     tdata = sorted_value
//                      m_tlast m_tuser               tlast = final_result
//                                                    tuser = overflow
//
//  An element is placed by scanning the store from the top entry down,
//  shifting each entry greater than it up one place (each shift is one
//  read-modify-write of the store); S_IDLE handles it alone when the
//  store is empty or full. Each result passes S_ERD, S_EOUT and S_EWAIT.
//  Reset leaves the store empty; no clearing pass is needed.
//  s_tready is high only between elements; m_tready stalls hold the output.
// ============================================================================
module insertion_sort_engine_top (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [ise_pkg::DATA_W-1:0]    s_tdata,   // [31:0] value
    input  logic                          s_tlast,   // final_item
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [ise_pkg::DATA_W-1:0]    m_tdata,   // [31:0] sorted_value
    output logic                          m_tlast,   // final_result
    output logic                          m_tuser    // [0] overflow
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_PLACE,
        S_ERD,
        S_EOUT,
        S_EWAIT
    } state_t;

    state_t                         state_reg, state_next;
    logic [ise_pkg::CNT_W-1:0]      fill_reg, fill_next;
    logic                           drop_reg, drop_next;
    logic signed [ise_pkg::DATA_W-1:0] val_reg, val_next;
    logic                           last_reg, last_next;
    logic [ise_pkg::ADDR_W-1:0]     idx_reg, idx_next;
    logic [ise_pkg::ADDR_W-1:0]     k_reg, k_next;
    logic                           mvalid_reg, mvalid_next;
    logic [ise_pkg::DATA_W-1:0]     mdata_reg, mdata_next;
    logic                           mlast_reg, mlast_next;
    logic                           muser_reg, muser_next;

    ise_pkg::ise_wr_t               wr;
    logic [ise_pkg::ADDR_W-1:0]     rd_addr;
    logic [ise_pkg::DATA_W-1:0]     rd_data;
    logic                           greater;
    logic [ise_pkg::CNT_W-1:0]      fill_m1;

    ise_store u_store (
        .clk     (clk),
        .wr      (wr),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign greater  = $signed(rd_data) > val_reg;
    assign fill_m1  = fill_reg - ise_pkg::CNT_W'(1);
    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = mvalid_reg;
    assign m_tdata  = mdata_reg;
    assign m_tlast  = mlast_reg;
    assign m_tuser  = muser_reg;

    // Next-state and store access
    always_comb
    begin
        state_next  = state_reg;
        fill_next   = fill_reg;
        drop_next   = drop_reg;
        val_next    = val_reg;
        last_next   = last_reg;
        idx_next    = idx_reg;
        k_next      = k_reg;
        mvalid_next = mvalid_reg;
        mdata_next  = mdata_reg;
        mlast_next  = mlast_reg;
        muser_next  = muser_reg;
        wr          = '0;
        rd_addr     = idx_reg - ise_pkg::ADDR_W'(1);

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    val_next  = s_tdata;
                    last_next = s_tlast;
                    k_next    = '0;
                    if (fill_reg == '0)
                    begin
                        // empty store: element goes straight to entry 0
                        wr.en      = 1'b1;
                        wr.addr    = '0;
                        wr.data    = s_tdata;
                        fill_next  = ise_pkg::CNT_W'(1);
                        state_next = s_tlast ? S_ERD : S_IDLE;
                    end
                    else if (fill_reg == ise_pkg::CNT_W'(ise_pkg::DEPTH))
                    begin
                        // full: drop, still emit on the final element
                        drop_next  = 1'b1;
                        state_next = s_tlast ? S_ERD : S_IDLE;
                    end
                    else
                    begin
                        rd_addr    = fill_m1[ise_pkg::ADDR_W-1:0];
                        idx_next   = fill_m1[ise_pkg::ADDR_W-1:0];
                        state_next = S_SCAN;
                    end
                end
            end

            S_SCAN:
            begin
                // rd_data holds entry idx; read of idx-1 is issued meanwhile
                wr.en   = 1'b1;
                wr.addr = idx_reg + ise_pkg::ADDR_W'(1);
                if (greater)
                begin
                    wr.data = rd_data;
                    if (idx_reg == '0)
                    begin
                        state_next = S_PLACE;
                    end
                    else
                    begin
                        idx_next = idx_reg - ise_pkg::ADDR_W'(1);
                    end
                end
                else
                begin
                    wr.data    = val_reg;
                    fill_next  = fill_reg + ise_pkg::CNT_W'(1);
                    state_next = last_reg ? S_ERD : S_IDLE;
                end
            end

            S_PLACE:
            begin
                // element is the new minimum
                wr.en      = 1'b1;
                wr.addr    = '0;
                wr.data    = val_reg;
                fill_next  = fill_reg + ise_pkg::CNT_W'(1);
                state_next = last_reg ? S_ERD : S_IDLE;
            end

            S_ERD:
            begin
                rd_addr    = k_reg;
                state_next = S_EOUT;
            end

            S_EOUT:
            begin
                mvalid_next = 1'b1;
                mdata_next  = rd_data;
                mlast_next  = (ise_pkg::CNT_W'(k_reg) == fill_m1);
                muser_next  = drop_reg;
                state_next  = S_EWAIT;
            end

            S_EWAIT:
            begin
                if (m_tready)
                begin
                    mvalid_next = 1'b0;
                    if (mlast_reg)
                    begin
                        fill_next  = '0;
                        drop_next  = 1'b0;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        k_next     = k_reg + ise_pkg::ADDR_W'(1);
                        state_next = S_ERD;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            fill_reg   <= '0;
            drop_reg   <= 1'b0;
            mvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            fill_reg   <= fill_next;
            drop_reg   <= drop_next;
            mvalid_reg <= mvalid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        val_reg   <= val_next;
        last_reg  <= last_next;
        idx_reg   <= idx_next;
        k_reg     <= k_next;
        mdata_reg <= mdata_next;
        mlast_reg <= mlast_next;
        muser_reg <= muser_next;
    end

endmodule

>>> sim/tb_insertion_sort_engine_top.sv
// ============================================================================
// tb_insertion_sort_engine_top
// Self-checking stream test of the insertion sort engine.
// ============================================================================
// Sets of signed elements are sent on the slave stream. A shadow copy of the
// sorted store predicts the ascending output run for each set, including the
// last flag and the overflow flag. Every output transfer is checked against
// the oldest prediction. The run covers directed corner sets, random sets of
// mixed sizes (some past the store depth), a long sink hold-off and three
// backpressure mixes.
// ============================================================================
module tb_insertion_sort_engine_top;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DATA_W = ise_pkg::DATA_W;
    localparam int DEPTH  = ise_pkg::DEPTH;

    localparam int CLK_PERIOD  = 4;
    localparam int RESET_CYC   = 5;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYC   = 4 * DEPTH + 64;
    localparam int HOLD_CYC    = 500;

    localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7fff_ffff;

    // Value mixes for random sets
    localparam int MIX_FULL    = 0;
    localparam int MIX_NARROW  = 1;
    localparam int MIX_EXTREME = 2;

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic                     final_item;
    } elem_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] sorted_value;
        logic                     final_result;
        logic                     overflow;
    } sorted_t;

    // DUT signals
    logic              clk      = 1'b0;
    logic              rst_n    = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [DATA_W-1:0] s_tdata  = '0;
    logic              s_tlast  = 1'b0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [DATA_W-1:0] m_tdata;
    logic              m_tlast;
    logic              m_tuser;

    // Stimulus and prediction state
    elem_t                    pending_elems[$];
    sorted_t                  expected_sorted[$];
    logic signed [DATA_W-1:0] shadow_store [DEPTH];
    int                       shadow_fill    = 0;
    logic                     shadow_dropped = 1'b0;

    int   src_idle_pct  = 24;
    int   sink_idle_pct = 50;
    logic sink_hold     = 1'b0;
    bit   hold_go       = 1'b0;
    int   queued_count  = 0;
    int   fail_count    = 0;
    int   cycle_count   = 0;

    insertion_sort_engine_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Shadow store: stable ascending insert, emit the whole set on the final element
    task automatic sort_insert(input logic signed [DATA_W-1:0] v, input logic fin);
        int      pos;
        sorted_t r;
        if (shadow_fill < DEPTH)
        begin
            pos = 0;
            while (pos < shadow_fill && shadow_store[pos] <= v)
                pos++;
            for (int i = shadow_fill; i > pos; i--)
                shadow_store[i] = shadow_store[i - 1];
            shadow_store[pos] = v;
            shadow_fill++;
        end
        else
            shadow_dropped = 1'b1;
        if (fin)
        begin
            for (int k = 0; k < shadow_fill; k++)
            begin
                r.sorted_value = shadow_store[k];
                r.final_result = (k == shadow_fill - 1);
                r.overflow     = shadow_dropped;
                expected_sorted.push_back(r);
            end
            shadow_fill    = 0;
            shadow_dropped = 1'b0;
        end
    endtask

    function automatic logic signed [DATA_W-1:0] pick_value(input int mix);
        logic signed [DATA_W-1:0] v;
        v = $urandom;
        if (mix == MIX_NARROW)
            v = $signed($urandom_range(0, 6)) - 3;
        else if (mix == MIX_EXTREME)
        begin
            case ($urandom_range(0, 5))
                0: v = VAL_MIN;
                1: v = VAL_MAX;
                2: v = 0;
                3: v = -1;
                4: v = 1;
                default: ;
            endcase
        end
        return v;
    endfunction

    task automatic push_elem(input logic signed [DATA_W-1:0] v, input logic fin);
        elem_t e;
        e.value      = v;
        e.final_item = fin;
        pending_elems.push_back(e);
        queued_count++;
    endtask

    // One set of n random elements, last one marked final
    task automatic queue_set(input int n);
        int mix;
        mix = $urandom_range(0, 3);
        if (mix > MIX_EXTREME)
            mix = MIX_FULL;
        @(negedge clk);
        for (int i = 0; i < n; i++)
            push_elem(pick_value(mix), i == n - 1);
    endtask

    task automatic queue_random_until(input int target);
        while (queued_count < target)
        begin
            if ($urandom_range(0, 11) == 0)
                queue_set($urandom_range(DEPTH - 1, DEPTH + 4));
            else
                queue_set($urandom_range(1, 8));
        end
    endtask

    task automatic wait_drained();
        while (pending_elems.size() != 0 || s_tvalid || expected_sorted.size() != 0)
            @(posedge clk);
    endtask

    task automatic set_idle(input int src_pct, input int sink_pct);
        @(negedge clk);
        src_idle_pct  = src_pct;
        sink_idle_pct = sink_pct;
    endtask

    // Slave-side driver: predict on each transfer, then offer the next element
    always @(posedge clk or negedge rst_n)
    begin
        elem_t nxt;
        bit    stuck;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tlast  <= 1'b0;
        end
        else
        begin
            stuck = s_tvalid && !s_tready;
            if (s_tvalid && s_tready)
                sort_insert(s_tdata, s_tlast);
            if (!stuck)
            begin
                if (pending_elems.size() != 0 && $urandom_range(99) >= src_idle_pct)
                begin
                    nxt = pending_elems.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= nxt.value;
                    s_tlast  <= nxt.final_item;
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // Master-side monitor: check each transfer against the oldest prediction
    always @(posedge clk or negedge rst_n)
    begin
        sorted_t got;
        sorted_t want;
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got = {m_tdata, m_tlast, m_tuser};
                if (expected_sorted.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, %s %0d last %0b ovf %0b",
                             $time, "got value",
                             got.sorted_value, got.final_result, got.overflow);
                    fail_count++;
                end
                else
                begin
                    want = expected_sorted.pop_front();
                    if (got !== want)
                    begin
                        $display("%0t: mismatch, expected value %0d last %0b ovf %0b, %s",
                                 $time, want.sorted_value, want.final_result,
                                 want.overflow, "got");
                        $display("%0t:   got value %0d last %0b ovf %0b",
                                 $time, got.sorted_value, got.final_result, got.overflow);
                        fail_count++;
                    end
                end
            end
            m_tready <= !sink_hold && ($urandom_range(99) >= sink_idle_pct);
        end
    end

    // Long sink hold-off, counted here in cycles
    initial
    begin
        forever
        begin
            wait (hold_go);
            @(posedge clk);
            sink_hold <= 1'b1;
            repeat (HOLD_CYC) @(posedge clk);
            sink_hold <= 1'b0;
            hold_go = 1'b0;
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Stimulus sequence
    initial
    begin
        repeat (RESET_CYC) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed sets: extremes, duplicates, sorted and reversed input, bit patterns
        @(negedge clk);
        push_elem(VAL_MIN, 1'b1);
        push_elem(VAL_MAX, 1'b1);
        push_elem(0, 1'b0);
        push_elem(-1, 1'b0);
        push_elem(VAL_MAX, 1'b0);
        push_elem(1, 1'b0);
        push_elem(VAL_MIN, 1'b0);
        push_elem(5, 1'b0);
        push_elem(5, 1'b0);
        push_elem(-1, 1'b1);
        push_elem(3, 1'b0);
        push_elem(3, 1'b0);
        push_elem(3, 1'b1);
        push_elem(-2, 1'b0);
        push_elem(0, 1'b0);
        push_elem(2, 1'b0);
        push_elem(4, 1'b1);
        push_elem(9, 1'b0);
        push_elem(7, 1'b0);
        push_elem(-7, 1'b0);
        push_elem(-9, 1'b1);
        push_elem(32'sh5555_5555, 1'b0);
        push_elem(32'shAAAA_AAAA, 1'b1);
        wait_drained();

        // Sender sparse-ish, sink stalls often
        queue_random_until(170);
        wait_drained();

        // Sink held off while a small set and an overflowing set queue up
        set_idle(50, 24);
        hold_go = 1'b1;
        queue_set(5);
        queue_set(DEPTH + 8);
        wait (!hold_go);
        wait_drained();

        queue_random_until(320);
        wait_drained();

        // Full rate both sides
        set_idle(0, 0);
        queue_random_until(470);

        wait_drained();
        repeat (DRAIN_CYC) @(posedge clk);
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
